FILE: rtl/fqd_pkg.sv
package fqd_pkg;

   localparam int DEF_SAMPLE_WIDTH  = 16;
   localparam int DEF_ANGLE_WIDTH   = 16;
   localparam int DEF_CORDIC_STAGES = 16;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   localparam int ACC_WIDTH = 32;
   localparam logic [ACC_WIDTH-1:0] ACC_PI = 32'h8000_0000;

   // atan(2^-k), 2^31 = pi
   localparam logic [ACC_WIDTH-1:0] ATAN_TABLE [0:31] = '{
      32'd536870912, 32'd316933406, 32'd167458908, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct packed {
      logic full;
      logic empty;
   } fqd_fifo_status_type;

   // low product bits dropped so the cordic cannot overflow
   function automatic int prod_shift(int sw);
      return (2 * sw > 61) ? (2 * sw - 61) : 0;
   endfunction

endpackage

FILE: rtl/fqd_fifo.sv
module fqd_fifo import fqd_pkg::*; #(
   parameter int WIDTH = DEF_ANGLE_WIDTH,
   parameter int DEPTH = OUT_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   output logic [WIDTH-1:0]    rd_data,
   output fqd_fifo_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
   assign rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

FILE: rtl/fqd_front.sv
module fqd_front import fqd_pkg::*; #(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                push,
   input  logic signed [SAMPLE_WIDTH-1:0]      sample_i,
   input  logic signed [SAMPLE_WIDTH-1:0]      sample_q,
   output logic                                out_push,
   output logic [2*SAMPLE_WIDTH-prod_shift(SAMPLE_WIDTH):0] out_re,
   output logic [2*SAMPLE_WIDTH-prod_shift(SAMPLE_WIDTH):0] out_im
);

   localparam int PW = 2 * SAMPLE_WIDTH;
   localparam int PS = prod_shift(SAMPLE_WIDTH);
   localparam int RW = PW - PS + 1;

   logic                           accept;
   logic signed [SAMPLE_WIDTH-1:0] prev_i_ff, prev_q_ff;
   logic                           st1_valid_ff, st2_valid_ff;
   logic signed [PW-1:0]           p_ac_ff, p_bd_ff, p_bc_ff, p_ad_ff;
   logic signed [PW-1:0]           p_ac_in, p_bd_in, p_bc_in, p_ad_in;
   logic [RW-1:0]                  re_ff, re_in, im_ff, im_in;

   assign accept = push && advance;

   // sample times conjugate of previous sample
   assign p_ac_in = sample_i * prev_i_ff;
   assign p_bd_in = sample_q * prev_q_ff;
   assign p_bc_in = sample_q * prev_i_ff;
   assign p_ad_in = sample_i * prev_q_ff;

   assign re_in = {p_ac_ff[PW-1], p_ac_ff[PW-1:PS]} + {p_bd_ff[PW-1], p_bd_ff[PW-1:PS]};
   assign im_in = {p_bc_ff[PW-1], p_bc_ff[PW-1:PS]} - {p_ad_ff[PW-1], p_ad_ff[PW-1:PS]};

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_i_ff    <= '0;
         prev_q_ff    <= '0;
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            prev_i_ff <= sample_i;
            prev_q_ff <= sample_q;
         end
         if (advance) begin
            st1_valid_ff <= accept;
            st2_valid_ff <= st1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ac_ff <= p_ac_in;
         p_bd_ff <= p_bd_in;
         p_bc_ff <= p_bc_in;
         p_ad_ff <= p_ad_in;
         re_ff   <= re_in;
         im_ff   <= im_in;
      end
   end

   assign out_push = advance && st2_valid_ff;
   assign out_re   = re_ff;
   assign out_im   = im_ff;

endmodule

FILE: rtl/fqd_back.sv
module fqd_back import fqd_pkg::*; #(
   parameter int SAMPLE_WIDTH  = DEF_SAMPLE_WIDTH,
   parameter int ANGLE_WIDTH   = DEF_ANGLE_WIDTH,
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [2*SAMPLE_WIDTH-prod_shift(SAMPLE_WIDTH):0] in_re,
   input  logic [2*SAMPLE_WIDTH-prod_shift(SAMPLE_WIDTH):0] in_im,
   output logic                   in_pop,
   output logic                   out_push,
   output logic [ANGLE_WIDTH-1:0] out_phase
);

   localparam int RW = 2 * SAMPLE_WIDTH - prod_shift(SAMPLE_WIDTH) + 1;
   localparam int XW = RW + 2;
   localparam int N  = CORDIC_STAGES;

   logic                        valid_ff [0:N];
   logic                        zero_ff  [0:N];
   logic signed [XW-1:0]        x_ff [0:N];
   logic signed [XW-1:0]        y_ff [0:N];
   logic [ACC_WIDTH-1:0]        z_ff [0:N];
   logic signed [XW-1:0]        x_in [0:N];
   logic signed [XW-1:0]        y_in [0:N];
   logic [ACC_WIDTH-1:0]        z_in [0:N];
   logic                        zero_in;
   logic signed [XW-1:0]        re_ext, im_ext;
   logic [ANGLE_WIDTH-1:0]      phase;

   assign in_pop = advance && in_valid;

   // left half plane is folded over by pi
   assign re_ext  = {{(XW-RW){in_re[RW-1]}}, in_re};
   assign im_ext  = {{(XW-RW){in_im[RW-1]}}, in_im};
   assign zero_in = (in_re == '0) && (in_im == '0);
   assign x_in[0] = in_re[RW-1] ? -re_ext : re_ext;
   assign y_in[0] = in_re[RW-1] ? -im_ext : im_ext;
   assign z_in[0] = in_re[RW-1] ? ACC_PI : '0;

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic signed [XW-1:0] xs, ys;
      logic                 y_pos;
      assign xs    = x_ff[k] >>> k;
      assign ys    = y_ff[k] >>> k;
      assign y_pos = !y_ff[k][XW-1] && (y_ff[k] != '0);
      assign x_in[k+1] = y_pos ? x_ff[k] + ys : x_ff[k] - ys;
      assign y_in[k+1] = y_pos ? y_ff[k] - xs : y_ff[k] + xs;
      assign z_in[k+1] = y_pos ? z_ff[k] + ATAN_TABLE[k] : z_ff[k] - ATAN_TABLE[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int k = 0; k < N; k++) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff[0] <= zero_in;
         for (int k = 0; k < N; k++) begin
            zero_ff[k+1] <= zero_ff[k];
         end
         for (int k = 0; k <= N; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
         end
      end
   end

   // round to nearest output step when narrower than the accumulator, wrapping at pi
   if (ANGLE_WIDTH < ACC_WIDTH) begin : g_round
      logic [ACC_WIDTH-1:0] z_round;
      assign z_round = z_ff[N] + (ACC_WIDTH'(1) << (ACC_WIDTH - 1 - ANGLE_WIDTH));
      assign phase   = z_round[ACC_WIDTH-1 -: ANGLE_WIDTH];
   end else begin : g_full
      assign phase = z_ff[N][ANGLE_WIDTH-1:0];
   end

   assign out_push  = advance && valid_ff[N];
   assign out_phase = zero_ff[N] ? '0 : phase;

endmodule

FILE: rtl/fm_quadrature_discriminator_top.sv
// channel   ports                              transfer when
// input     push, full, req_sample_i/_q        push && !full
// result    empty, pop, rsp_phase_step         pop && !empty
//
// one sample per cycle sustained while full is low
// latency: two multiply/sum stages, middle queue, fold stage, one per cordic step
// synchronous reset clears the previous sample to zero and empties both queues
// a stalled result side halts the cordic pipe; the middle queue fills, then full rises

module fm_quadrature_discriminator_top import fqd_pkg::*; #(
   parameter int SAMPLE_WIDTH  = DEF_SAMPLE_WIDTH,
   parameter int ANGLE_WIDTH   = DEF_ANGLE_WIDTH,
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_i,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_q,
   output logic                           empty,
   input  logic                           pop,
   output logic signed [ANGLE_WIDTH-1:0]  rsp_phase_step
);

   localparam int RW = 2 * SAMPLE_WIDTH - prod_shift(SAMPLE_WIDTH) + 1;

   fqd_fifo_status_type    mid_status, out_status;
   logic                   front_push;
   logic [RW-1:0]          front_re, front_im;
   logic [2*RW-1:0]        mid_data;
   logic                   back_pop, back_push;
   logic [ANGLE_WIDTH-1:0] back_phase, out_data;

   fqd_front #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (!mid_status.full),
      .push     (push),
      .sample_i (req_sample_i),
      .sample_q (req_sample_q),
      .out_push (front_push),
      .out_re   (front_re),
      .out_im   (front_im)
   );

   fqd_fifo #(
      .WIDTH(2 * RW),
      .DEPTH(MID_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_push),
      .wr_data ({front_re, front_im}),
      .rd_en   (back_pop),
      .rd_data (mid_data),
      .status  (mid_status)
   );

   fqd_back #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .ANGLE_WIDTH   (ANGLE_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (!out_status.full),
      .in_valid  (!mid_status.empty),
      .in_re     (mid_data[2*RW-1:RW]),
      .in_im     (mid_data[RW-1:0]),
      .in_pop    (back_pop),
      .out_push  (back_push),
      .out_phase (back_phase)
   );

   fqd_fifo #(
      .WIDTH(ANGLE_WIDTH),
      .DEPTH(OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (back_push),
      .wr_data (back_phase),
      .rd_en   (pop && !out_status.empty),
      .rd_data (out_data),
      .status  (out_status)
   );

   assign full           = mid_status.full;
   assign empty          = out_status.empty;
   assign rsp_phase_step = out_data;

endmodule

FILE: rtl/fqd_checker.sv
module fqd_checker import fqd_pkg::*; #(
   parameter int ANGLE_WIDTH = DEF_ANGLE_WIDTH
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   push,
   input logic                   full,
   input logic                   empty,
   input logic                   pop,
   input logic [ANGLE_WIDTH-1:0] rsp_phase_step
);

   // right after reset full is low and the result queue stays empty
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !full && empty ##1 empty ##1 empty)
      else $error("result or full too soon after reset");

   // input side backs up only behind a waiting result
   a_full_needs_result: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("full without a waiting result");

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_phase_step))
      else $error("result changed while waiting");

endmodule

bind fm_quadrature_discriminator_top fqd_checker #(
   .ANGLE_WIDTH(ANGLE_WIDTH)
) u_fqd_checker (
   .clock          (clock),
   .reset          (reset),
   .push           (push),
   .full           (full),
   .empty          (empty),
   .pop            (pop),
   .rsp_phase_step (rsp_phase_step)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import fqd_pkg::*;

   localparam int SW = DEF_SAMPLE_WIDTH;
   localparam int AW = DEF_ANGLE_WIDTH;
   localparam int STAGES = DEF_CORDIC_STAGES;
   localparam int IDLE_PCT = 29;
   localparam int HOLD_LEN = 400;
   localparam int STALL_LIMIT = 3000;
   localparam int TAIL_CYCLES = STAGES + 12;
   localparam logic [31:0] ANGLE_PI = 32'h8000_0000;
   localparam real TWO_PI = 6.283185307179586;

   typedef struct packed {
      logic signed [SW-1:0] sample_i;
      logic signed [SW-1:0] sample_q;
      logic signed [AW-1:0] phase;
   } phase_expect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic signed [SW-1:0] req_sample_i = '0;
   logic signed [SW-1:0] req_sample_q = '0;
   logic empty;
   logic pop = 1'b0;
   logic signed [AW-1:0] rsp_phase_step;

   phase_expect_type pending_phase[$];
   logic signed [SW-1:0] last_i = '0;
   logic signed [SW-1:0] last_q = '0;
   bit tx_idle_en = 1'b1;
   bit rx_idle_en = 1'b1;
   int hold_tickets = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int samples_sent = 0;
   int steps_checked = 0;
   int mismatches = 0;
   int full_cycles = 0;
   int stall_count = 0;

   fm_quadrature_discriminator_top DUT (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_sample_i   (req_sample_i),
      .req_sample_q   (req_sample_q),
      .empty          (empty),
      .pop            (pop),
      .rsp_phase_step (rsp_phase_step)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // atan(2^-k) with 2^31 = pi
   function automatic logic [31:0] arctan_step(input int k);
      case (k)
         0: return 32'd536870912;
         1: return 32'd316933406;
         2: return 32'd167458908;
         3: return 32'd85004756;
         4: return 32'd42667331;
         5: return 32'd21354465;
         6: return 32'd10679838;
         7: return 32'd5340245;
         8: return 32'd2670163;
         9: return 32'd1335087;
         10: return 32'd667544;
         11: return 32'd333772;
         12: return 32'd166886;
         13: return 32'd83443;
         14: return 32'd41722;
         15: return 32'd20861;
         16: return 32'd10430;
         17: return 32'd5215;
         18: return 32'd2608;
         19: return 32'd1304;
         20: return 32'd652;
         21: return 32'd326;
         22: return 32'd163;
         23: return 32'd81;
         24: return 32'd41;
         25: return 32'd20;
         26: return 32'd10;
         27: return 32'd5;
         28: return 32'd3;
         29: return 32'd1;
         30: return 32'd1;
         default: return 32'd0;
      endcase
   endfunction

   // phase of cur * conj(prev), vectoring cordic with floor shifts
   function automatic logic signed [AW-1:0] discriminate(
      input logic signed [SW-1:0] cur_i, input logic signed [SW-1:0] cur_q,
      input logic signed [SW-1:0] prev_i, input logic signed [SW-1:0] prev_q);
      longint re, im, x, y, xs, ys;
      logic [31:0] acc;
      int k;
      re = longint'(cur_i) * longint'(prev_i) + longint'(cur_q) * longint'(prev_q);
      im = longint'(cur_q) * longint'(prev_i) - longint'(cur_i) * longint'(prev_q);
      if (re == 0 && im == 0) return '0;
      acc = '0;
      x = re;
      y = im;
      if (re < 0) begin
         x = -re;
         y = -im;
         acc = ANGLE_PI;
      end
      for (k = 0; k < STAGES; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            acc = acc + arctan_step(k);
         end else begin
            x = x - ys;
            y = y + xs;
            acc = acc - arctan_step(k);
         end
      end
      acc = acc + (32'd1 << (31 - AW));
      return acc[31 -: AW];
   endfunction

   task automatic sender_idle(input int cycles);
      repeat (cycles) begin
         push <= 1'b0;
         req_sample_i <= SW'($urandom);
         req_sample_q <= SW'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic send_sample(input logic signed [SW-1:0] si, input logic signed [SW-1:0] sq);
      phase_expect_type e;
      if (tx_idle_en && $urandom_range(99) < IDLE_PCT) sender_idle($urandom_range(1, 4));
      push <= 1'b1;
      req_sample_i <= si;
      req_sample_q <= sq;
      do @(posedge clock); while (full);
      e.sample_i = si;
      e.sample_q = sq;
      e.phase = discriminate(si, sq, last_i, last_q);
      pending_phase.push_back(e);
      last_i = si;
      last_q = sq;
      samples_sent++;
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (pending_phase.size() != 0) @(posedge clock);
   endtask

   // result side: check each transfer, then choose the next pop
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_phase.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected phase step %0d with nothing pending", rsp_phase_step);
         end else begin
            phase_expect_type e;
            e = pending_phase.pop_front();
            steps_checked++;
            if (rsp_phase_step !== e.phase) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("phase step mismatch for sample (%0d, %0d): expected %0d, got %0d",
                           e.sample_i, e.sample_q, e.phase, rsp_phase_step);
            end
         end
      end
      if (hold_tickets != hold_seen) begin
         hold_seen = hold_tickets;
         hold_left = HOLD_LEN;
      end
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         pop <= !(rx_idle_en && $urandom_range(99) < IDLE_PCT);
      end
   end

   // watchdog on cycles without any transfer, also counts cycles the input is held off by full
   always @(posedge clock) begin
      if (!reset) begin
         if (push && full) full_cycles++;
         if ((push && !full) || (pop && !empty)) begin
            stall_count <= 0;
         end else if (stall_count >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("fm_quadrature_discriminator_top regression: fail");
            $finish;
         end else begin
            stall_count <= stall_count + 1;
         end
      end
   end

   task automatic test_directed_extremes();
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sd32767, 16'sd0);
      send_sample(16'sd0, 16'sd32767);
      send_sample(-16'sd32768, 16'sd0);
      send_sample(16'sd0, -16'sd32768);
      send_sample(-16'sd32768, -16'sd32768);
      send_sample(16'sd32767, 16'sd32767);
      send_sample(16'sd32767, -16'sd32768);
      send_sample(-16'sd32768, 16'sd32767);
      send_sample(-16'sd1, -16'sd1);
      send_sample(16'sd1, 16'sd0);
      send_sample(-16'sd1, 16'sd0);
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sd32767, 16'sd0);
      send_sample(-16'sd32768, -16'sd1);
      send_sample(16'sd32767, 16'sd0);
      send_sample(-16'sd32768, 16'sd1);
      send_sample(16'sd1, 16'sd1);
      send_sample(16'sd1, -16'sd1);
      send_sample(16'sd2, 16'sd0);
      send_sample(16'sd32767, 16'sd1);
   endtask

   // phasor whose frequency drifts at random now and then, the normal fm input
   task automatic test_fm_tone(input int count);
      real amp, ph, step;
      int n;
      amp = real'($urandom_range(1, 32767));
      ph = TWO_PI * real'($urandom_range(0, 999)) / 1000.0;
      step = TWO_PI * (real'($urandom_range(0, 2000)) - 1000.0) / 2000.0;
      for (n = 0; n < count; n++) begin
         send_sample(SW'(int'(amp * $cos(ph))), SW'(int'(amp * $sin(ph))));
         ph = ph + step;
         if ($urandom_range(9) == 0) step = step + (real'($urandom_range(0, 200)) - 100.0) / 1000.0;
      end
   endtask

   task automatic test_random_noise(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(3) == 0)
            send_sample(SW'($signed($urandom_range(0, 6)) - 3), SW'($signed($urandom_range(0, 6)) - 3));
         else
            send_sample(SW'($urandom), SW'($urandom));
      end
   endtask

   task automatic test_backpressure();
      tx_idle_en = 1'b0;
      hold_tickets++;
      test_fm_tone(60);
      wait_drained();
      tx_idle_en = 1'b1;
   endtask

   task automatic test_drain_pause();
      test_random_noise(20);
      wait_drained();
      test_fm_tone(20);
      wait_drained();
   endtask

   task automatic test_no_idle_stretch();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      test_fm_tone(70);
      test_random_noise(60);
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
   endtask

   initial begin
      int b;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      for (b = 0; b < 8; b++) test_fm_tone(40);
      test_random_noise(80);
      test_backpressure();
      test_drain_pause();
      test_no_idle_stretch();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_phase.size() != 0) begin
         mismatches++;
         $display("%0d phase steps never arrived", pending_phase.size());
      end
      $display("%0d samples sent (extremes, fm tones, noise), %0d phase steps checked",
               samples_sent, steps_checked);
      $display("input held off by full for %0d cycles, %0d mismatches", full_cycles, mismatches);
      if (mismatches == 0) begin
         $display("fm_quadrature_discriminator_top regression: pass");
      end else begin
         $display("fm_quadrature_discriminator_top regression: fail");
      end
      $finish;
   end

endmodule
